@@ hw/rtl/radix_digit_emitter_defines.svh @@
// Assertion macros shared by the RTL of the radix digit emitter.
// Define NO_ASSERTIONS to compile them out.
`ifndef RADIX_DIGIT_EMITTER_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked only while the block is out of reset.
`define RDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define RDE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define RDE_ASSERT(lbl, prop, msg)
`define RDE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/rde_pkg.sv @@
`default_nettype none

package rde_pkg;

    // Datapath sizing.
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RADIX   = 16;
    localparam int DIV_BITS    = 8;
    localparam int DIV_CYCLES  = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int QUO_W       = DIV_CYCLES * DIV_BITS;
    localparam int BC_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
    localparam int DIG_W       = 4;
    localparam int REM_W       = 5;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = $clog2(VALUE_WIDTH);
    localparam int SYM_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int PC_W        = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMS_HIGH = 2'd2;

    localparam logic [REM_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [REM_W-1:0] RADIX_MAX   = REM_W'(MAX_RADIX);
    localparam logic [REM_W-1:0] RADIX_RESET = 5'd16;

    // Microprogram addresses.
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd0;
    localparam logic [PC_W-1:0] STEP_STORE = 3'd1;
    localparam logic [PC_W-1:0] STEP_RD    = 3'd2;
    localparam logic [PC_W-1:0] STEP_PUT   = 3'd3;
    localparam logic [PC_W-1:0] STEP_IDLE  = 3'd4;

    // Condition that keeps the sequencer on its current step.
    typedef enum logic [1:0] {
        HOLD_NONE     = 2'd0,
        HOLD_NO_ITEM  = 2'd1,
        HOLD_OUT_BUSY = 2'd2
    } t_hold;

    // Condition that sends the sequencer to the target step.
    typedef enum logic [2:0] {
        JMP_NEVER    = 3'd0,
        JMP_ALWAYS   = 3'd1,
        JMP_DIV_MORE = 3'd2,
        JMP_QUO_NZ   = 3'd3,
        JMP_MORE_DIG = 3'd4
    } t_jump;

    typedef struct packed {
        logic            load;
        logic            div;
        logic            store;
        logic            rd;
        logic            put;
        t_hold           hold;
        t_jump           jump;
        logic [PC_W-1:0] target;
    } t_ctl;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic in_fire;
        logic out_busy;
        logic div_more;
        logic quo_nz;
        logic more_dig;
    } t_cond;

    // Datapath strobes; all but ready are gated by the hold condition.
    typedef struct packed {
        logic ready;
        logic load;
        logic div;
        logic store;
        logic rd;
        logic put;
    } t_act;

    // The microprogram.
    function automatic t_ctl prog_word(input logic [PC_W-1:0] pc);
        t_ctl w;
        w = '{load: 1'b0, div: 1'b0, store: 1'b0, rd: 1'b0, put: 1'b0,
              hold: HOLD_NONE, jump: JMP_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_DIV: begin
                w.div    = 1'b1;
                w.jump   = JMP_DIV_MORE;
                w.target = STEP_DIV;
            end
            STEP_STORE: begin
                w.store  = 1'b1;
                w.jump   = JMP_QUO_NZ;
                w.target = STEP_DIV;
            end
            STEP_RD: begin
                w.rd   = 1'b1;
                w.jump = JMP_NEVER;
            end
            STEP_PUT: begin
                w.put    = 1'b1;
                w.hold   = HOLD_OUT_BUSY;
                w.jump   = JMP_MORE_DIG;
                w.target = STEP_RD;
            end
            STEP_IDLE: begin
                w.load   = 1'b1;
                w.hold   = HOLD_NO_ITEM;
                w.jump   = JMP_ALWAYS;
                w.target = STEP_DIV;
            end
            default: begin
                w.jump   = JMP_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/radix_digit_emitter.sv @@
`default_nettype none
// A new item is accepted only after the last digit of the previous one has been
// loaded into the output register (a 64-bit value has up to 20 digits in decimal).
// Each digit costs division steps of 8 quotient bits each plus a store, then a read
// and an output load from the digit RAM; the microprogram sets this.
// Reset (synchronous, active low): radix 16, symbol table zero, no item in flight.
`include "radix_digit_emitter_defines.svh"

module radix_digit_emitter
    import rde_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input items. tdata: value[63:0].
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [63:0]          i_s_tdata,
    // Result items. tdata: symbol[7:0], digit_count[14:8], zero[15].
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic      [15:0]          o_m_tdata,
    output logic                      o_m_tlast,
    // Configuration writes.
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [63:0]          i_cfg_data
);

    // Configuration registers.
    logic [REM_W-1:0] r_radix;
    logic [63:0]      r_syms_lo;
    logic [63:0]      r_syms_hi;
    logic [REM_W-1:0] eff_radix;

    // Datapath registers.
    logic [QUO_W-1:0] r_quo;
    logic [REM_W-1:0] r_rem;
    logic [BC_W-1:0]  r_bc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_total;

    // Output register.
    logic             r_out_valid;
    logic [SYM_W-1:0] r_out_sym;
    logic             r_out_last;
    logic [CNT_W-1:0] r_out_cnt;

    t_cond            cond;
    t_act             act;
    logic             in_fire;
    logic [QUO_W-1:0] div_quo;
    logic [REM_W-1:0] div_rem;
    logic [CNT_W-1:0] rd_idx;
    logic [DIG_W-1:0] rd_digit;
    logic [SYM_W-1:0] symbol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= RADIX_RESET;
            r_syms_lo <= '0;
            r_syms_hi <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIX:     r_radix   <= i_cfg_data[REM_W-1:0];
                REG_SYMS_LOW:  r_syms_lo <= i_cfg_data;
                REG_SYMS_HIGH: r_syms_hi <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // Radix saturated into the supported range.
    always_comb begin
        if (r_radix < RADIX_MIN) begin
            eff_radix = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            eff_radix = RADIX_MAX;
        end else begin
            eff_radix = r_radix;
        end
    end

    // Sequencer.
    assign in_fire       = i_s_tvalid && o_s_tready;
    assign cond.in_fire  = in_fire;
    assign cond.out_busy = r_out_valid && !i_m_tready;
    assign cond.div_more = (r_bc != BC_W'(DIV_CYCLES - 1));
    assign cond.quo_nz   = (r_quo != '0);
    assign cond.more_dig = (r_cnt != CNT_W'(1));

    rde_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (cond),
        .o_act   (act)
    );

    assign o_s_tready = act.ready;

    // Restoring division: DIV_BITS quotient bits per cycle, remainder stays narrow.
    always_comb begin
        div_quo = r_quo;
        div_rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            div_rem = {div_rem[REM_W-2:0], div_quo[QUO_W-1]};
            div_quo = {div_quo[QUO_W-2:0], 1'b0};
            if (div_rem >= eff_radix) begin
                div_rem    = div_rem - eff_radix;
                div_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc  <= '0;
            r_cnt <= '0;
        end else if (act.load) begin
            r_bc  <= '0;
            r_cnt <= '0;
        end else if (act.div) begin
            r_bc  <= r_bc + BC_W'(1);
        end else if (act.store) begin
            r_bc  <= '0;
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (act.put) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (act.load) begin
            r_quo <= QUO_W'(i_s_tdata[VALUE_WIDTH-1:0]);
            r_rem <= '0;
        end else if (act.div) begin
            r_quo <= div_quo;
            r_rem <= div_rem;
        end else if (act.store) begin
            r_rem   <= '0;
            r_total <= r_cnt + CNT_W'(1);
        end
    end

    // Digit buffer: written least significant first, read back in reverse.
    assign rd_idx = r_cnt - CNT_W'(1);

    rde_ram #(
        .WIDTH (DIG_W),
        .DEPTH (VALUE_WIDTH)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (act.store),
        .i_waddr (r_cnt[ADDR_W-1:0]),
        .i_wdata (r_rem[DIG_W-1:0]),
        .i_re    (act.rd),
        .i_raddr (rd_idx[ADDR_W-1:0]),
        .o_rdata (rd_digit)
    );

    // Symbol table lookup.
    always_comb begin
        if (rd_digit[DIG_W-1]) begin
            symbol = r_syms_hi[{rd_digit[DIG_W-2:0], 3'b000} +: SYM_W];
        end else begin
            symbol = r_syms_lo[{rd_digit[DIG_W-2:0], 3'b000} +: SYM_W];
        end
    end

    // Output register; the next item can be taken while it waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (act.put) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (act.put) begin
            r_out_sym  <= symbol;
            r_out_last <= !cond.more_dig;
            r_out_cnt  <= cond.more_dig ? '0 : r_total;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {1'b0, r_out_cnt, r_out_sym};

    // A new item starts with a clean digit count and division phase.
    `RDE_ASSERT(a_load_clears, in_fire |=> (r_cnt == '0 && r_bc == '0), "load did not clear")
    // The digit count never exceeds the value width.
    `RDE_ASSERT_ALWAYS(a_cnt_range, !i_rst_n || r_cnt <= CNT_W'(VALUE_WIDTH), "count overflow")
    // The last item of a run carries a nonzero count, the others zero.
    `RDE_ASSERT(a_last_cnt, (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[14:8] != 7'd0), "last count zero")
    `RDE_ASSERT(a_mid_cnt, (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[14:8] == 7'd0), "middle count set")
    // An output item is never overwritten before it is taken.
    `RDE_ASSERT(a_no_overwrite, (o_m_tvalid && !i_m_tready) |-> !act.put, "output overwritten")

endmodule

`default_nettype wire

@@ hw/rtl/rde_ram.sv @@
`default_nettype none

// Simple dual-port RAM with a registered read.
module rde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/rde_seq.sv @@
`default_nettype none

// Microprogram sequencer: step counter, control ROM and jump logic.
module rde_seq
    import rde_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cond i_cond,
    output t_act       o_act
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ctl            ctl;
    logic            held;
    logic            take;

    assign ctl = prog_word(r_pc);

    // Hold condition decode.
    always_comb begin
        unique case (ctl.hold)
            HOLD_NONE:     held = 1'b0;
            HOLD_NO_ITEM:  held = !i_cond.in_fire;
            HOLD_OUT_BUSY: held = i_cond.out_busy;
            default:       held = 1'b0;
        endcase
    end

    // Jump condition decode.
    always_comb begin
        unique case (ctl.jump)
            JMP_NEVER:    take = 1'b0;
            JMP_ALWAYS:   take = 1'b1;
            JMP_DIV_MORE: take = i_cond.div_more;
            JMP_QUO_NZ:   take = i_cond.quo_nz;
            JMP_MORE_DIG: take = i_cond.more_dig;
            default:      take = 1'b1;
        endcase
    end

    // Next step.
    always_comb begin
        if (held) begin
            n_pc = r_pc;
        end else if (take) begin
            n_pc = ctl.target;
        end else begin
            n_pc = r_pc + PC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // Strobes to the datapath.
    assign o_act.ready = ctl.load;
    assign o_act.load  = ctl.load  && !held;
    assign o_act.div   = ctl.div   && !held;
    assign o_act.store = ctl.store && !held;
    assign o_act.rd    = ctl.rd    && !held;
    assign o_act.put   = ctl.put   && !held;

endmodule

`default_nettype wire
